@@ design/rc5bp_pkg.sv @@
// Shared types and constants for the RC5 bi-phase frame decoder.
// Used by the symbol/result interfaces, the controller, the datapath and the top level.
package rc5bp_pkg;

	localparam int DUR_W     = 15;
	localparam int FRAME_BITS = 13;
	localparam int CNT_W     = 4;
	localparam int IDX_W     = 7;
	localparam int ADDR_W    = 5;
	localparam int CMD_W     = 7;
	localparam int TOL_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BITS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL = 1'b1;

	localparam logic [CNT_W-1:0] MIN_BITS_RST = 4'd12;
	localparam logic [TOL_W-1:0] MATCH_TOL_RST = 10'd200;

	// controller -> datapath
	typedef struct packed {
		logic latch;       // input transfer, capture the symbol
		logic check;       // first-mark test
		logic load_mark;   // half-bit remainder from mark
		logic load_space;  // half-bit remainder from space
		logic step;        // feed one half-bit
		logic done_mark;   // close mark duration
		logic done_space;  // close space duration
		logic emit;        // write result, clear burst
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic take_ok;     // symbol's durations are decoded
		logic more;        // another half-bit to feed
		logic last;        // captured symbol ends the burst
		logic out_busy;    // result register still holds an untaken result
	} sts_t;

endpackage

@@ design/rc5bp_sym_if.sv @@
// Input channel: one received IR symbol per transfer.
// Depends on rc5bp_pkg for field widths.
interface rc5bp_sym_if;
	import rc5bp_pkg::*;

	logic             valid;
	logic             ready;
	logic [DUR_W-1:0] mark_us;
	logic [DUR_W-1:0] gap_us;
	logic             last_symbol;

	modport source (output valid, mark_us, gap_us, last_symbol, input ready);
	modport sink (input valid, mark_us, gap_us, last_symbol, output ready);
endinterface

@@ design/rc5bp_res_if.sv @@
// Output channel: one decoded frame result per transfer.
// Depends on rc5bp_pkg for field widths.
interface rc5bp_res_if;
	import rc5bp_pkg::*;

	logic              valid;
	logic              ready;
	logic              frame_ok;
	logic [ADDR_W-1:0] address;
	logic [CMD_W-1:0]  command;
	logic [CNT_W-1:0]  bits_decoded;

	modport source (output valid, frame_ok, address, command, bits_decoded, input ready);
	modport sink (input valid, frame_ok, address, command, bits_decoded, output ready);
endinterface

@@ design/rc5bp_ctrl.sv @@
// Sequencer for the RC5 decoder: steps each symbol through first-mark test,
// half-bit feeding of mark and space, and result emission. Uses rc5bp_pkg.
module rc5bp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rc5bp_pkg::sts_t sts,
	output rc5bp_pkg::cmd_t cmd
);
	import rc5bp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GATE,
		ST_RUN_MARK,
		ST_RUN_SPACE,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:      cmd.latch = in_valid;
			ST_CHECK:     cmd.check = 1'b1;
			ST_GATE:      cmd.load_mark = sts.take_ok;
			ST_RUN_MARK: begin
				cmd.step       = sts.more;
				cmd.done_mark  = !sts.more;
				cmd.load_space = !sts.more;
			end
			ST_RUN_SPACE: begin
				cmd.step       = sts.more;
				cmd.done_space = !sts.more;
			end
			ST_EMIT:      cmd.emit = !sts.out_busy;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: state_q <= ST_GATE;
				ST_GATE: begin
					if (sts.take_ok)   state_q <= ST_RUN_MARK;
					else if (sts.last) state_q <= ST_EMIT;
					else               state_q <= ST_IDLE;
				end
				ST_RUN_MARK: begin
					if (!sts.more) state_q <= ST_RUN_SPACE;
				end
				ST_RUN_SPACE: begin
					if (!sts.more) state_q <= sts.last ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/rc5bp_dp.sv @@
// Datapath for the RC5 decoder: config registers, burst state, half-bit
// remainder, bi-phase bit assembly and the result register. Uses rc5bp_pkg.
module rc5bp_dp #(
	parameter int HALF_BIT_US   = 889,
	parameter int MAX_DURATIONS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rc5bp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rc5bp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [rc5bp_pkg::DUR_W-1:0]          mark_us,
	input  logic [rc5bp_pkg::DUR_W-1:0]          gap_us,
	input  logic                                 last_symbol,
	input  rc5bp_pkg::cmd_t                      cmd,
	output rc5bp_pkg::sts_t                      sts,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic                                 frame_ok,
	output logic [rc5bp_pkg::ADDR_W-1:0]         address,
	output logic [rc5bp_pkg::CMD_W-1:0]          command,
	output logic [rc5bp_pkg::CNT_W-1:0]          bits_decoded
);
	import rc5bp_pkg::*;

	// remainder holds d + HALF/2 and counts down one unit per fed half-bit
	localparam int REM_W = $clog2((1 << DUR_W) + HALF_BIT_US / 2);
	localparam int NEAR_W = DUR_W + 2;
	localparam logic [REM_W-1:0] UNIT = REM_W'(HALF_BIT_US);
	localparam logic [REM_W-1:0] ROUND = REM_W'(HALF_BIT_US / 2);
	localparam logic [NEAR_W-1:0] ONE_U = NEAR_W'(HALF_BIT_US);
	localparam logic [NEAR_W-1:0] TWO_U = NEAR_W'(HALF_BIT_US * 2);
	localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(MAX_DURATIONS);
	localparam logic [IDX_W-1:0] IDX_MAX = '1;
	localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

	typedef enum logic [1:0] {
		PH_START,
		PH_FIRST,
		PH_SECOND,
		PH_STOP
	} phase_t;

	logic [CNT_W-1:0]      min_bits_q;
	logic [TOL_W-1:0]      tol_q;

	logic [DUR_W-1:0]      mark_q;
	logic [DUR_W-1:0]      space_q;
	logic                  last_q;
	logic [REM_W-1:0]      rem_q;

	logic                  first_seen_q;
	logic                  start_failed_q;
	logic [IDX_W-1:0]      idx_q;
	phase_t                phase_q;
	logic                  held_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic [CNT_W-1:0]      count_q;

	logic                  res_valid_q;
	logic                  frame_ok_q;
	logic [ADDR_W-1:0]     address_q;
	logic [CMD_W-1:0]      command_q;
	logic [CNT_W-1:0]      bits_q;

	logic [NEAR_W-1:0]     mark_x;
	logic [NEAR_W-1:0]     diff1;
	logic [NEAR_W-1:0]     diff2;
	logic                  near_ok;
	logic                  level;
	logic [CNT_W-1:0]      bit_pos;
	logic                  ok;
	logic [DUR_W-1:0]      done_dur;

	always_comb begin
		mark_x  = NEAR_W'(mark_q);
		diff1   = (mark_x >= ONE_U) ? mark_x - ONE_U : ONE_U - mark_x;
		diff2   = (mark_x >= TWO_U) ? mark_x - TWO_U : TWO_U - mark_x;
		near_ok = (diff1 <= NEAR_W'(tol_q)) || (diff2 <= NEAR_W'(tol_q));
	end

	assign level   = ~idx_q[0];
	assign bit_pos = FRAME_CNT - 4'd1 - count_q;
	assign ok      = !start_failed_q && (phase_q != PH_START) && (count_q >= min_bits_q);
	assign done_dur = cmd.done_space ? space_q : mark_q;

	assign sts.take_ok  = !start_failed_q && (idx_q < IDX_CAP);
	assign sts.more     = (rem_q >= UNIT) && (phase_q != PH_STOP);
	assign sts.last     = last_q;
	assign sts.out_busy = res_valid_q && !res_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bits_q <= MIN_BITS_RST;
			tol_q      <= MATCH_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MIN_BITS:  min_bits_q <= cfg_wdata[CNT_W-1:0];
				CFG_MATCH_TOL: tol_q <= cfg_wdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// symbol capture and half-bit remainder
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mark_q  <= mark_us;
			space_q <= gap_us;
			last_q  <= last_symbol;
		end
		if (cmd.load_mark)       rem_q <= REM_W'(mark_q) + ROUND;
		else if (cmd.load_space) rem_q <= REM_W'(space_q) + ROUND;
		else if (cmd.step)       rem_q <= rem_q - UNIT;
	end

	// burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seen_q   <= 1'b0;
			start_failed_q <= 1'b0;
			idx_q          <= '0;
			phase_q        <= PH_START;
			held_q         <= 1'b0;
			shift_q        <= '0;
			count_q        <= '0;
		end else if (cmd.emit) begin
			first_seen_q   <= 1'b0;
			start_failed_q <= 1'b0;
			idx_q          <= '0;
			phase_q        <= PH_START;
			held_q         <= 1'b0;
			shift_q        <= '0;
			count_q        <= '0;
		end else begin
			if (cmd.check && !first_seen_q) begin
				first_seen_q <= 1'b1;
				if (!near_ok) start_failed_q <= 1'b1;
			end
			if ((cmd.done_mark || cmd.done_space) && done_dur != '0 && idx_q != IDX_MAX)
				idx_q <= idx_q + 7'd1;
			if (cmd.step) begin
				case (phase_q)
					PH_START: begin
						if (level) begin
							phase_q <= PH_FIRST;
						end else begin
							start_failed_q <= 1'b1;
							phase_q        <= PH_STOP;
						end
					end
					PH_FIRST: begin
						held_q  <= level;
						phase_q <= PH_SECOND;
					end
					PH_SECOND: begin
						if (held_q != level && count_q < FRAME_CNT) begin
							// 0-then-1 is a one
							if (!held_q) shift_q[bit_pos] <= 1'b1;
							count_q <= count_q + 4'd1;
							phase_q <= (count_q + 4'd1 >= FRAME_CNT) ? PH_STOP : PH_FIRST;
						end else begin
							phase_q <= PH_STOP;
						end
					end
					default: phase_q <= PH_STOP;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			frame_ok_q <= ok;
			address_q  <= ok ? shift_q[10:6] : '0;
			// field bit is the first decoded bit; a zero marks the extended set
			command_q  <= ok ? {~shift_q[FRAME_BITS-1], shift_q[5:0]} : '0;
			bits_q     <= start_failed_q ? '0 : count_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_ok     = frame_ok_q;
	assign address      = address_q;
	assign command      = command_q;
	assign bits_decoded = bits_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FRAME_CNT)
		else $error("bit count beyond frame length");

	a_full_stops: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == FRAME_CNT |-> phase_q == PH_STOP)
		else $error("decoding continues past a full frame");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> count_q == '0 && phase_q == PH_START && !first_seen_q && res_valid_q)
		else $error("burst state not cleared on result");

endmodule

@@ design/rc5_biphase_frame_decoder.sv @@
// RC5 bi-phase frame decoder, top level.
// Symbol handling: each symbol is captured, first-mark tested and gated; if its durations are skipped
// it is done, else the half-bits of its mark and then of its space are fed (at most 27 half-bits
// per burst); after the last symbol the result is written.
// One symbol is handled at a time; the next symbol is taken while one result waits.
// Reset (arst_n low, asynchronous) clears burst state, restores register defaults.
module rc5_biphase_frame_decoder #(
	parameter int HALF_BIT_US   = 889,
	parameter int MAX_DURATIONS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rc5bp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rc5bp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	rc5bp_sym_if.sink                            sym,
	rc5bp_res_if.source                          res
);
	import rc5bp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rc5bp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sym.valid),
		.in_ready (sym.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rc5bp_dp #(
		.HALF_BIT_US   (HALF_BIT_US),
		.MAX_DURATIONS (MAX_DURATIONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.mark_us      (sym.mark_us),
		.gap_us       (sym.gap_us),
		.last_symbol  (sym.last_symbol),
		.cmd          (cmd),
		.sts          (sts),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.frame_ok     (res.frame_ok),
		.address      (res.address),
		.command      (res.command),
		.bits_decoded (res.bits_decoded)
	);

endmodule
